// ===== rtl/sgprs_pkg.sv =====
// ----------------------------------------------------------------------------
// sgprs_pkg
// shared types and constants of the scatter-gather pair read segmenter
// ----------------------------------------------------------------------------
package sgprs_pkg;

	localparam int ADDR_W   = 64;
	localparam int LEN_W    = 32;
	localparam int KEY_W    = 64;
	localparam int OFFS_W   = 36;
	localparam int CMD_W    = 3;
	localparam int STAT_W   = 2;
	localparam int LIDX_W   = 4;
	localparam int CFG_IDX_W = 2;

	localparam int IN_DATA_W  = 200;
	localparam int OUT_DATA_W = 232;

	localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND_L = 3'd1;
	localparam logic [CMD_W-1:0] CMD_APPEND_R = 3'd2;
	localparam logic [CMD_W-1:0] CMD_START    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_NEXT     = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_SEG  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NONE = 2'd2;
	localparam logic [STAT_W-1:0] STAT_ERR  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_EN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_XFER_LIM  = 2'd2;

	localparam logic [LEN_W-1:0] SEG_SIZE_RST = 32'd262144;
	localparam logic [LEN_W-1:0] XFER_LIM_RST = 32'd1073741824;
	localparam logic [OFFS_W-1:0] OFFS_MAX    = 36'hF_FFFF_FFFF;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] local_address;
		logic [ADDR_W-1:0] remote_address;
		logic [LEN_W-1:0]  length;
		logic [KEY_W-1:0]  key;
		logic [LIDX_W-1:0] local_index;
		logic              last;
	} res_t;

endpackage

// ===== rtl/sg_pair_read_segmenter.sv =====
// ----------------------------------------------------------------------------
// sg_pair_read_segmenter
// splits one remote read into segments over a local and a remote scatter list
//
// commands arrive on the s_axis stream, kind in tuser; one result beat per
// command leaves on m_axis, status in tuser, last-segment mark in tlast.
// the lists sit in two rams (local: base and length, remote: address, length
// and key) with registered read data.
// clear, append and unknown commands finish in the dispatch state after accept.
// next segment runs through accept, ram read, length clamp, address add
// and walk update.
// start sums both lists and searches them for the start offset one entry per
// ram read, as far as the longer list reaches.
// one command is in work at a time; the next is accepted once the result of
// the previous one sits in the output register.
// a stalled receiver holds the result; work waits only when a new result
// finds the output register still full.
// reset empties both lists and the walk state and restores the limit
// registers; list ram contents are not cleared and need no pass.
// ----------------------------------------------------------------------------
module sg_pair_read_segmenter
	import sgprs_pkg::*;
#(
	parameter int MAX_LOCAL_ENTRIES  = 16,
	parameter int MAX_REMOTE_ENTRIES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [LEN_W-1:0]      cfg_data,

	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// entry_address, entry_length, entry_key, start_offset, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// command
	input  logic [CMD_W-1:0]      s_axis_tuser,

	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// seg_local_address, seg_remote_address, seg_length, seg_key,
	// seg_local_index, zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// status
	output logic [STAT_W-1:0]     m_axis_tuser,
	// seg_last
	output logic                  m_axis_tlast
);

	localparam int LCW = $clog2(MAX_LOCAL_ENTRIES + 1);
	localparam int RCW = $clog2(MAX_REMOTE_ENTRIES + 1);
	localparam int LAW = (MAX_LOCAL_ENTRIES > 1) ? $clog2(MAX_LOCAL_ENTRIES) : 1;
	localparam int RAW = (MAX_REMOTE_ENTRIES > 1) ? $clog2(MAX_REMOTE_ENTRIES) : 1;
	localparam int KW  = (LCW > RCW) ? LCW : RCW;
	localparam int WW  = (LEN_W + KW > OFFS_W + 1) ? LEN_W + KW : OFFS_W + 1;
	localparam int LRAM_W = ADDR_W + LEN_W;
	localparam int RRAM_W = ADDR_W + LEN_W + KEY_W;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DISP   = 7'b0000010,
		S_WK_RD  = 7'b0000100,
		S_WK_ACC = 7'b0001000,
		S_WK_FIN = 7'b0010000,
		S_NX_A   = 7'b0100000,
		S_NX_B   = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration
	logic             limit_en_q;
	logic [LEN_W-1:0] seg_size_q;
	logic [LEN_W-1:0] xfer_lim_q;

	// captured command
	logic [CMD_W-1:0]  cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;
	logic [KEY_W-1:0]  key_q;
	logic [OFFS_W-1:0] start_q;

	// list and walk state
	logic [LCW-1:0]    lcount_q;
	logic [RCW-1:0]    rcount_q;
	logic [LCW-1:0]    lidx_q;
	logic [RCW-1:0]    ridx_q;
	logic [LEN_W-1:0]  loff_q;
	logic [LEN_W-1:0]  roff_q;
	logic [OFFS_W-1:0] issued_q;
	logic [OFFS_W-1:0] total_q;

	// start walk
	logic [KW-1:0]    k_q;
	logic [WW-1:0]    lsum_q;
	logic [WW-1:0]    rsum_q;
	logic             lfound_q;
	logic             rfound_q;
	logic [LCW-1:0]   lfidx_q;
	logic [RCW-1:0]   rfidx_q;
	logic [LEN_W-1:0] lfpos_q;
	logic [LEN_W-1:0] rfpos_q;

	// next segment stage
	logic [LEN_W-1:0] seg_s1;
	logic             empty_s1;

	// rams
	logic              l_we;
	logic              l_re;
	logic [LAW-1:0]    l_raddr;
	logic [LRAM_W-1:0] l_rdata;
	logic              r_we;
	logic              r_re;
	logic [RAW-1:0]    r_raddr;
	logic [RRAM_W-1:0] r_rdata;

	logic [ADDR_W-1:0] l_rbase;
	logic [LEN_W-1:0]  l_rlen;
	logic [ADDR_W-1:0] r_raddr_d;
	logic [LEN_W-1:0]  r_rlen;
	logic [KEY_W-1:0]  r_rkey;

	// output
	logic m_valid_q;
	res_t res_q;
	res_t res;
	logic fin;
	logic out_free;

	logic in_acc;
	logic l_ok;
	logic r_ok;

	// walk helpers
	logic            k_in_l;
	logic            k_in_r;
	logic [WW-1:0]   lsum_nx;
	logic [WW-1:0]   rsum_nx;
	logic            l_hit;
	logic            r_hit;
	logic [WW-1:0]   start_w;
	logic [WW-1:0]   tot_w;
	logic [OFFS_W-1:0] tot36;
	logic            start_bad;

	// segment helpers
	logic             nx_empty;
	logic [LEN_W-1:0] lrem;
	logic [LEN_W-1:0] rrem;
	logic [LEN_W-1:0] seg0;
	logic [LEN_W-1:0] lim_a;
	logic [LEN_W-1:0] lim_b;
	logic [LEN_W-1:0] seg1;
	logic [LEN_W-1:0] seg2;
	logic [OFFS_W-1:0] left;
	logic [LEN_W-1:0] loff_nx;
	logic [LEN_W-1:0] roff_nx;
	logic             l_adv;
	logic             r_adv;
	logic [OFFS_W-1:0] issued_nx;
	logic [LCW+LIDX_W-1:0] lidx_ext;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	assign l_ok = (len_q != '0) && (lcount_q < LCW'(MAX_LOCAL_ENTRIES));
	assign r_ok = (len_q != '0) && (rcount_q < RCW'(MAX_REMOTE_ENTRIES));

	// ram control
	always_comb begin
		l_we    = (state_q == S_DISP) && (cmd_q == CMD_APPEND_L) && out_free && l_ok;
		r_we    = (state_q == S_DISP) && (cmd_q == CMD_APPEND_R) && out_free && r_ok;
		l_re    = 1'b0;
		r_re    = 1'b0;
		l_raddr = k_q[LAW-1:0];
		r_raddr = k_q[RAW-1:0];
		if (state_q == S_DISP && cmd_q == CMD_NEXT) begin
			l_re    = 1'b1;
			r_re    = 1'b1;
			l_raddr = lidx_q[LAW-1:0];
			r_raddr = ridx_q[RAW-1:0];
		end else if (state_q == S_WK_RD) begin
			l_re = 1'b1;
			r_re = 1'b1;
		end
	end

	sgprs_ram #(
		.WIDTH (LRAM_W),
		.DEPTH (MAX_LOCAL_ENTRIES)
	) u_local_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (lcount_q[LAW-1:0]),
		.wdata ({len_q, addr_q}),
		.re    (l_re),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	sgprs_ram #(
		.WIDTH (RRAM_W),
		.DEPTH (MAX_REMOTE_ENTRIES)
	) u_remote_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (rcount_q[RAW-1:0]),
		.wdata ({key_q, len_q, addr_q}),
		.re    (r_re),
		.raddr (r_raddr),
		.rdata (r_rdata)
	);

	assign l_rbase   = l_rdata[ADDR_W-1:0];
	assign l_rlen    = l_rdata[ADDR_W+LEN_W-1:ADDR_W];
	assign r_raddr_d = r_rdata[ADDR_W-1:0];
	assign r_rlen    = r_rdata[ADDR_W+LEN_W-1:ADDR_W];
	assign r_rkey    = r_rdata[RRAM_W-1:ADDR_W+LEN_W];

	// list walk for start
	always_comb begin
		start_w   = WW'(start_q);
		k_in_l    = k_q < KW'(lcount_q);
		k_in_r    = k_q < KW'(rcount_q);
		lsum_nx   = lsum_q + WW'(l_rlen);
		rsum_nx   = rsum_q + WW'(r_rlen);
		l_hit     = k_in_l && !lfound_q && (start_w < lsum_nx);
		r_hit     = k_in_r && !rfound_q && (start_w < rsum_nx);
		tot_w     = (lsum_q < rsum_q) ? lsum_q : rsum_q;
		tot36     = (tot_w > WW'(OFFS_MAX)) ? OFFS_MAX : tot_w[OFFS_W-1:0];
		start_bad = start_q > tot36;
	end

	// segment length and walk update
	always_comb begin
		nx_empty  = (issued_q >= total_q) || (lidx_q >= lcount_q) || (ridx_q >= rcount_q);
		lrem      = l_rlen - loff_q;
		rrem      = r_rlen - roff_q;
		seg0      = (lrem < rrem) ? lrem : rrem;
		lim_a     = (seg_size_q == '0) ? LEN_W'(1) : seg_size_q;
		lim_b     = (xfer_lim_q == '0) ? LEN_W'(1) : xfer_lim_q;
		seg1      = seg0;
		if (limit_en_q) begin
			if (seg1 > lim_a) begin
				seg1 = lim_a;
			end
			if (seg1 > lim_b) begin
				seg1 = lim_b;
			end
		end
		left      = total_q - issued_q;
		seg2      = (OFFS_W'(seg1) > left) ? left[LEN_W-1:0] : seg1;
		loff_nx   = loff_q + seg_s1;
		roff_nx   = roff_q + seg_s1;
		l_adv     = loff_nx == l_rlen;
		r_adv     = roff_nx == r_rlen;
		issued_nx = issued_q + OFFS_W'(seg_s1);
		lidx_ext  = (LCW+LIDX_W)'(lidx_q);
	end

	// result of the finishing cycle
	always_comb begin
		fin = 1'b0;
		res = '0;
		case (state_q)
			S_DISP: begin
				fin = out_free && (cmd_q != CMD_START) && (cmd_q != CMD_NEXT);
				case (cmd_q)
					CMD_CLEAR:    res.status = STAT_OK;
					CMD_APPEND_L: res.status = l_ok ? STAT_OK : STAT_ERR;
					CMD_APPEND_R: res.status = r_ok ? STAT_OK : STAT_ERR;
					default:      res.status = STAT_ERR;
				endcase
			end
			S_WK_FIN: begin
				fin        = out_free;
				res.status = start_bad ? STAT_ERR : STAT_OK;
			end
			S_NX_B: begin
				fin = out_free;
				if (empty_s1) begin
					res.status = STAT_NONE;
				end else begin
					res.status         = STAT_SEG;
					res.local_address  = l_rbase + ADDR_W'(loff_q);
					res.remote_address = r_raddr_d + ADDR_W'(roff_q);
					res.length         = seg_s1;
					res.key            = r_rkey;
					res.local_index    = lidx_ext[LIDX_W-1:0];
					res.last           = issued_nx == total_q;
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			limit_en_q <= 1'b1;
			seg_size_q <= SEG_SIZE_RST;
			xfer_lim_q <= XFER_LIM_RST;
			lcount_q   <= '0;
			rcount_q   <= '0;
			lidx_q     <= '0;
			ridx_q     <= '0;
			loff_q     <= '0;
			roff_q     <= '0;
			issued_q   <= '0;
			total_q    <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LIMIT_EN: limit_en_q <= cfg_data[0];
					REG_SEG_SIZE: seg_size_q <= cfg_data;
					REG_XFER_LIM: xfer_lim_q <= cfg_data;
					default:      limit_en_q <= limit_en_q;
				endcase
			end

			if (fin) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					case (cmd_q)
						CMD_START: state_q <= S_WK_RD;
						CMD_NEXT:  state_q <= S_NX_A;
						default: begin
							if (out_free) begin
								state_q <= S_IDLE;
							end
						end
					endcase
					if (out_free && cmd_q == CMD_CLEAR) begin
						lcount_q <= '0;
						rcount_q <= '0;
						lidx_q   <= '0;
						ridx_q   <= '0;
						loff_q   <= '0;
						roff_q   <= '0;
						issued_q <= '0;
						total_q  <= '0;
					end
					if (l_we) begin
						lcount_q <= lcount_q + LCW'(1);
					end
					if (r_we) begin
						rcount_q <= rcount_q + RCW'(1);
					end
				end
				S_WK_RD: begin
					if (!k_in_l && !k_in_r) begin
						state_q <= S_WK_FIN;
					end else begin
						state_q <= S_WK_ACC;
					end
				end
				S_WK_ACC: begin
					state_q <= S_WK_RD;
				end
				S_WK_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (start_bad) begin
							lidx_q   <= '0;
							ridx_q   <= '0;
							loff_q   <= '0;
							roff_q   <= '0;
							issued_q <= '0;
							total_q  <= '0;
						end else begin
							total_q  <= tot36;
							issued_q <= start_q;
							lidx_q   <= lfound_q ? lfidx_q : lcount_q;
							loff_q   <= lfound_q ? lfpos_q : '0;
							ridx_q   <= rfound_q ? rfidx_q : rcount_q;
							roff_q   <= rfound_q ? rfpos_q : '0;
						end
					end
				end
				S_NX_A: begin
					state_q <= S_NX_B;
				end
				S_NX_B: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (!empty_s1) begin
							issued_q <= issued_nx;
							if (l_adv) begin
								lidx_q <= lidx_q + LCW'(1);
								loff_q <= '0;
							end else begin
								loff_q <= loff_nx;
							end
							if (r_adv) begin
								ridx_q <= ridx_q + RCW'(1);
								roff_q <= '0;
							end else begin
								roff_q <= roff_nx;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q   <= s_axis_tuser;
			addr_q  <= s_axis_tdata[63:0];
			len_q   <= s_axis_tdata[95:64];
			key_q   <= s_axis_tdata[159:96];
			start_q <= s_axis_tdata[195:160];
		end

		if (state_q == S_DISP) begin
			k_q      <= '0;
			lsum_q   <= '0;
			rsum_q   <= '0;
			lfound_q <= 1'b0;
			rfound_q <= 1'b0;
		end else if (state_q == S_WK_ACC) begin
			k_q <= k_q + KW'(1);
			if (k_in_l) begin
				lsum_q <= lsum_nx;
			end
			if (k_in_r) begin
				rsum_q <= rsum_nx;
			end
			if (l_hit) begin
				lfound_q <= 1'b1;
				lfidx_q  <= LCW'(k_q);
				lfpos_q  <= LEN_W'(start_w - lsum_q);
			end
			if (r_hit) begin
				rfound_q <= 1'b1;
				rfidx_q  <= RCW'(k_q);
				rfpos_q  <= LEN_W'(start_w - rsum_q);
			end
		end

		if (state_q == S_NX_A) begin
			seg_s1   <= seg2;
			empty_s1 <= nx_empty;
		end

		if (fin) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = res_q.status;
	assign m_axis_tlast  = res_q.last;
	assign m_axis_tdata  = {4'b0000, res_q.local_index, res_q.key, res_q.length,
	                        res_q.remote_address, res_q.local_address};

endmodule

// ===== rtl/sgprs_ram.sv =====
// ----------------------------------------------------------------------------
// sgprs_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module sgprs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the scatter-gather pair read segmenter against a cycle-free predictor
// of its list walk: a directed run over the corner cases, then random
// clear/append/start/next sequences under several limit settings and idling
// mixes on both stream sides, every result beat compared field by field
// ----------------------------------------------------------------------------
module tb;
	import sgprs_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam longint unsigned CYCLE_LIMIT = 1000000;
	localparam int ITEMS_TARGET = 1650;
	localparam int PHASES = 8;
	localparam int REPORT_MAX = 10;
	localparam int DRAIN_CYCLES = 50;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	class segmenter_scoreboard;
		logic [ADDR_W-1:0] lbase [LIST_DEPTH];
		logic [LEN_W-1:0]  llen  [LIST_DEPTH];
		logic [ADDR_W-1:0] raddr [LIST_DEPTH];
		logic [LEN_W-1:0]  rlen  [LIST_DEPTH];
		logic [KEY_W-1:0]  rkey  [LIST_DEPTH];
		int unsigned lcount, rcount, lidx, ridx;
		logic [LEN_W-1:0] loff, roff;
		logic [OFFS_W-1:0] issued, total;
		logic lim_en;
		logic [LEN_W-1:0] seg_sz, xfer_lim;
		res_t segment_answers [$];
		int unsigned mismatches;

		function new();
			lcount = 0;
			rcount = 0;
			rewind();
			lim_en = 1'b1;
			seg_sz = SEG_SIZE_RST;
			xfer_lim = XFER_LIM_RST;
			mismatches = 0;
		endfunction

		function void rewind();
			lidx = 0;
			ridx = 0;
			loff = '0;
			roff = '0;
			issued = '0;
			total = '0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
			case (idx)
			REG_LIMIT_EN: lim_en = val[0];
			REG_SEG_SIZE: seg_sz = val;
			REG_XFER_LIM: xfer_lim = val;
			default: ;
			endcase
		endfunction

		// smaller list sum, saturated to the offset width
		function logic [OFFS_W-1:0] list_total();
			longint unsigned ls, rs, m;
			ls = 0;
			rs = 0;
			for (int i = 0; i < lcount; i++) ls += llen[i];
			for (int i = 0; i < rcount; i++) rs += rlen[i];
			m = (ls < rs) ? ls : rs;
			if (m > OFFS_MAX) m = OFFS_MAX;
			return OFFS_W'(m);
		endfunction

		// entry holding byte off; past the end gives (count, 0)
		function void find_position(bit remote, logic [OFFS_W-1:0] off,
				output int unsigned idx, output logic [LEN_W-1:0] pos);
			longint unsigned cur, len;
			int unsigned cnt;
			cnt = remote ? rcount : lcount;
			cur = 0;
			idx = cnt;
			pos = '0;
			for (int i = 0; i < cnt; i++) begin
				len = remote ? rlen[i] : llen[i];
				if (off >= cur && off < cur + len) begin
					idx = i;
					pos = LEN_W'(off - cur);
					return;
				end
				cur += len;
			end
		endfunction

		function void note_command(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
				logic [LEN_W-1:0] len, logic [KEY_W-1:0] key, logic [OFFS_W-1:0] offs);
			res_t r;
			logic [OFFS_W-1:0] tot;
			longint unsigned lrem, rrem, seg, cap;
			r = '0;
			r.status = STAT_OK;
			case (cmd)
			CMD_CLEAR: begin
				lcount = 0;
				rcount = 0;
				rewind();
			end
			CMD_APPEND_L: begin
				if (len == 0 || lcount >= LIST_DEPTH) begin
					r.status = STAT_ERR;
				end else begin
					lbase[lcount] = addr;
					llen[lcount] = len;
					lcount++;
				end
			end
			CMD_APPEND_R: begin
				if (len == 0 || rcount >= LIST_DEPTH) begin
					r.status = STAT_ERR;
				end else begin
					raddr[rcount] = addr;
					rlen[rcount] = len;
					rkey[rcount] = key;
					rcount++;
				end
			end
			CMD_START: begin
				tot = list_total();
				rewind();
				if (offs > tot) begin
					r.status = STAT_ERR;
				end else begin
					total = tot;
					issued = offs;
					find_position(1'b0, offs, lidx, loff);
					find_position(1'b1, offs, ridx, roff);
				end
			end
			CMD_NEXT: begin
				if (issued >= total || lidx >= lcount || ridx >= rcount) begin
					r.status = STAT_NONE;
				end else begin
					lrem = llen[lidx] - loff;
					rrem = rlen[ridx] - roff;
					seg = (lrem < rrem) ? lrem : rrem;
					if (lim_en) begin
						cap = (seg_sz == 0) ? 1 : seg_sz;
						if (seg > cap) seg = cap;
						cap = (xfer_lim == 0) ? 1 : xfer_lim;
						if (seg > cap) seg = cap;
					end
					if (seg > total - issued) seg = total - issued;
					r.status = STAT_SEG;
					r.local_address = lbase[lidx] + loff;
					r.remote_address = raddr[ridx] + roff;
					r.length = LEN_W'(seg);
					r.key = rkey[ridx];
					r.local_index = LIDX_W'(lidx);
					r.last = (issued + seg == total);
					issued = issued + OFFS_W'(seg);
					loff = loff + LEN_W'(seg);
					if (loff == llen[lidx]) begin
						lidx++;
						loff = '0;
					end
					roff = roff + LEN_W'(seg);
					if (roff == rlen[ridx]) begin
						ridx++;
						roff = '0;
					end
				end
			end
			default: r.status = STAT_ERR;
			endcase
			segment_answers.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (segment_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result beat: status %0d length %h",
						got.status, got.length);
				return;
			end
			want = segment_answers.pop_front();
			if (got.status !== want.status || got.local_address !== want.local_address ||
					got.remote_address !== want.remote_address ||
					got.length !== want.length || got.key !== want.key ||
					got.local_index !== want.local_index || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("mismatch: status exp %0d got %0d, index exp %0d got %0d, last exp %0b got %0b",
						want.status, got.status, want.local_index, got.local_index,
						want.last, got.last);
					$display("  local exp %h got %h, remote exp %h got %h",
						want.local_address, got.local_address,
						want.remote_address, got.remote_address);
					$display("  length exp %h got %h, key exp %h got %h",
						want.length, got.length, want.key, got.key);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LEN_W-1:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata;
	logic [CMD_W-1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [STAT_W-1:0] m_axis_tuser;
	logic m_axis_tlast;

	segmenter_scoreboard scoreboard = new();
	int unsigned sent = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	longint unsigned cycles = 0;

	sg_pair_read_segmenter uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: check accepted beats, stall at random
	always @(posedge clk) begin
		res_t got;
		if (m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tuser;
			got.local_address = m_axis_tdata[63:0];
			got.remote_address = m_axis_tdata[127:64];
			got.length = m_axis_tdata[159:128];
			got.key = m_axis_tdata[223:160];
			got.local_index = m_axis_tdata[227:224];
			got.last = m_axis_tlast;
			scoreboard.check_result(got);
		end
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [LEN_W-1:0] rand_len();
		int unsigned pick;
		logic [LEN_W-1:0] v;
		pick = $urandom_range(99);
		v = $urandom;
		if (pick < 3) return '0;
		if (pick < 60) return $urandom_range(1, 64);
		if (pick < 82) return $urandom_range(1, 100000);
		if (pick < 95) return (v == 0) ? LEN_W'(1) : v;
		return LEN_MAX;
	endfunction

	function automatic int list_size();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 80) return $urandom_range(1, 6);
		if (pick < 88) return $urandom_range(7, 15);
		if (pick < 92) return LIST_DEPTH;
		if (pick < 96) return $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 2);
		return 0;
	endfunction

	task automatic send_command(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
			logic [LEN_W-1:0] len, logic [KEY_W-1:0] key, logic [OFFS_W-1:0] offs);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= IN_DATA_W'({offs, key, len, addr});
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		scoreboard.note_command(cmd, addr, len, key, offs);
		sent++;
	endtask

	task automatic send_noise();
		send_command(CMD_W'($urandom_range(7)), rand64(), rand_len(), rand64(),
			OFFS_W'(rand64()));
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		scoreboard.set_reg(idx, val);
	endtask

	// stop sending and let every pending result drain
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (scoreboard.segment_answers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic directed_run();
		send_command(CMD_CLEAR, rand64(), $urandom, rand64(), OFFS_W'(rand64()));
		send_command(CMD_APPEND_L, '1, LEN_MAX, '0, '0);
		send_command(CMD_APPEND_L, '0, LEN_W'(1), '1, '0);
		send_command(CMD_APPEND_L, rand64(), '0, rand64(), '0);
		send_command(CMD_APPEND_R, '1, LEN_W'(100), '1, '0);
		send_command(CMD_APPEND_R, '0, LEN_MAX, '0, '1);
		send_command(CMD_APPEND_R, rand64(), '0, rand64(), '0);
		// offset past total, then nothing left
		send_command(CMD_START, '0, '0, '0, OFFS_MAX);
		send_command(CMD_NEXT, '0, '0, '0, '0);
		send_command(CMD_START, '0, '0, '0, '0);
		send_command(CMD_NEXT, '1, LEN_MAX, '1, OFFS_MAX);
		send_command(CMD_NEXT, '0, '0, '0, '0);
		// offset equal to total
		send_command(CMD_START, '0, '0, '0, OFFS_W'(LEN_MAX) + 1);
		send_command(CMD_NEXT, '0, '0, '0, '0);
		// last byte only
		send_command(CMD_START, '0, '0, '0, OFFS_W'(LEN_MAX));
		send_command(CMD_NEXT, '0, '0, '0, '0);
		send_command(CMD_NEXT, '0, '0, '0, '0);
		// append after start leaves the total alone
		send_command(CMD_APPEND_L, rand64(), LEN_W'(5), '0, '0);
		send_command(CMD_NEXT, '0, '0, '0, '0);
		for (int k = 1; k <= 3; k++)
			send_command(CMD_NEXT + CMD_W'(k), rand64(), $urandom, rand64(), OFFS_W'(rand64()));
		send_command(CMD_CLEAR, '0, '0, '0, '0);
		send_command(CMD_NEXT, '0, '0, '0, '0);
		send_command(CMD_START, '0, '0, '0, '0);
	endtask

	task automatic random_sequence();
		int n_local, n_remote, n_next;
		int unsigned pick;
		logic [OFFS_W-1:0] tot, offs;
		send_command(CMD_CLEAR, rand64(), $urandom, rand64(), OFFS_W'(rand64()));
		n_local = list_size();
		n_remote = list_size();
		while (n_local + n_remote > 0) begin
			if (n_remote == 0 || (n_local > 0 && $urandom_range(1))) begin
				send_command(CMD_APPEND_L, rand64(), rand_len(), rand64(), OFFS_W'(rand64()));
				n_local--;
			end else begin
				send_command(CMD_APPEND_R, rand64(), rand_len(), rand64(), OFFS_W'(rand64()));
				n_remote--;
			end
		end
		tot = scoreboard.list_total();
		pick = $urandom_range(99);
		if (pick < 45)
			offs = '0;
		else if (pick < 70)
			offs = OFFS_W'(rand64() % (64'(tot) + 64'd1));
		else if (pick < 80)
			offs = tot;
		else if (pick < 92)
			offs = (tot >= OFFS_MAX - 4) ? OFFS_MAX : tot + 1 + OFFS_W'($urandom_range(3));
		else
			offs = OFFS_W'(rand64());
		send_command(CMD_START, rand64(), $urandom, rand64(), offs);
		n_next = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		repeat (n_next) begin
			pick = $urandom_range(99);
			if (pick < 4)
				send_command($urandom_range(1) ? CMD_APPEND_L : CMD_APPEND_R,
					rand64(), rand_len(), rand64(), OFFS_W'(rand64()));
			else if (pick < 8)
				send_noise();
			else
				send_command(CMD_NEXT, rand64(), $urandom, rand64(), OFFS_W'(rand64()));
		end
	endtask

	task automatic apply_phase(int p);
		case (p % 4)
		0: begin send_idle_pct = 0;  stall_pct = 0;  end
		1: begin send_idle_pct = 87; stall_pct = 0;  end
		2: begin send_idle_pct = 0;  stall_pct = 87; end
		default: begin send_idle_pct = 17; stall_pct = 17; end
		endcase
		case (p)
		1: write_reg(REG_LIMIT_EN, LEN_W'(0));
		2: begin
			write_reg(REG_LIMIT_EN, LEN_W'(1));
			write_reg(REG_SEG_SIZE, '0);
			write_reg(REG_XFER_LIM, '0);
		end
		3: begin
			write_reg(REG_SEG_SIZE, LEN_MAX);
			write_reg(REG_XFER_LIM, LEN_MAX);
		end
		4: begin
			write_reg(REG_SEG_SIZE, $urandom_range(1, 5000));
			write_reg(REG_XFER_LIM, $urandom_range(1, 5000));
		end
		5: begin
			write_reg(REG_SEG_SIZE, SEG_SIZE_RST);
			write_reg(REG_XFER_LIM, LEN_W'(1));
		end
		6: begin
			write_reg(REG_LIMIT_EN, LEN_W'(0));
			write_reg(REG_SEG_SIZE, $urandom);
			write_reg(REG_XFER_LIM, $urandom);
		end
		7: begin
			write_reg(REG_LIMIT_EN, LEN_W'(1));
			write_reg(REG_SEG_SIZE, $urandom);
			write_reg(REG_XFER_LIM, $urandom_range(1, 300));
		end
		default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int unsigned base;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_LIMIT_EN;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= CMD_CLEAR;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_run();
		base = sent;
		for (int p = 0; p < PHASES; p++) begin
			settle();
			apply_phase(p);
			while (sent < base + (p + 1) * ITEMS_TARGET / PHASES) random_sequence();
		end
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (scoreboard.mismatches == 0 && scoreboard.segment_answers.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
